// ----- design/ptwm_pkg.sv -----
// ptwm_pkg: shared constants, types and codes for the page table walk and map unit.
// No dependencies; imported by ptwm_entry_unit and the top level.
`default_nettype none

package ptwm_pkg;

  // Pool geometry
  localparam int TABLE_COUNT = 64;
  localparam int ENTRY_COUNT = 512;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int TBL_W       = $clog2(TABLE_COUNT);
  localparam int NFREE_W     = $clog2(TABLE_COUNT + 1);
  localparam int STORE_DEPTH = TABLE_COUNT * ENTRY_COUNT;
  localparam int ADDR_W      = TBL_W + IDX_W;

  localparam int ENTRY_W = 64;
  localparam int FRAME_W = 40;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PAGE_SHIFT = 12;

  localparam logic [ENTRY_W-1:0] KEEP_MASK    = 64'hfff0_0000_0000_0fff;
  localparam logic [ENTRY_W-1:0] BIT_PRESENT  = 64'h1;
  localparam logic [ENTRY_W-1:0] BIT_WRITABLE = 64'h2;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_POOL_EMPTY  = 2'd2;

  localparam logic [1:0] LEVEL_ROOT = 2'd0;
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  // Mode codes
  localparam logic MODE_MAP    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic REG_POOL_BASE = 1'b0;

  // Entry decode result from the shared entry unit
  typedef struct packed {
    logic             present;
    logic [TBL_W-1:0] tbl;
  } link_t;

endpackage

`default_nettype wire

// ----- design/ptwm_ram.sv -----
// ptwm_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module ptwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/ptwm_entry_unit.sv -----
// ptwm_entry_unit: shared entry decoder and merger used at every walk level.
// Depends on ptwm_pkg.
`default_nettype none

module ptwm_entry_unit import ptwm_pkg::*; (
  input  wire logic [ENTRY_W-1:0] entry_i,
  input  wire logic [FRAME_W-1:0] base_i,
  input  wire logic [NFREE_W-1:0] next_free_i,
  input  wire logic               is_leaf_i,
  input  wire logic [FRAME_W-1:0] leaf_frame_i,
  input  wire logic [ENTRY_W-1:0] leaf_flags_i,
  output link_t                   link_o,
  output logic      [ENTRY_W-1:0] merged_o
);

  logic [FRAME_W-1:0] ent_frame;
  logic [FRAME_W-1:0] rel;
  logic [FRAME_W-1:0] alloc_frame;
  logic [FRAME_W-1:0] new_frame;
  logic [ENTRY_W-1:0] new_flags;

  // Pointer check: present bit and frame inside the handed-out part of the pool
  assign ent_frame      = entry_i[PAGE_SHIFT +: FRAME_W];
  assign rel            = ent_frame - base_i;
  assign link_o.present = entry_i[0] && (rel < FRAME_W'(next_free_i));
  assign link_o.tbl     = rel[TBL_W-1:0];

  // Frame for a freshly allocated table, or the mapped frame at the leaf
  assign alloc_frame = base_i + FRAME_W'(next_free_i);
  assign new_frame   = is_leaf_i ? leaf_frame_i : alloc_frame;
  assign new_flags   = is_leaf_i ? leaf_flags_i : (BIT_PRESENT | BIT_WRITABLE);

  assign merged_o = (entry_i & KEEP_MASK)
                  | {12'h000, new_frame, 12'h000}
                  | new_flags;

endmodule

`default_nettype wire

// ----- design/page_table_walk_and_map_unit.sv -----
// page_table_walk_and_map_unit: top level, sequencer, config port and output register.
// Depends on ptwm_pkg, ptwm_ram and ptwm_entry_unit.
`default_nettype none

// Four-level page table walker with on-chip table pool. Each item either maps
// (mode 0) or looks up (mode 1) a 48-bit virtual address; bits 47..39, 38..30,
// 29..21 and 20..12 index the root, levels 1 and 2 and the leaf table. The
// pool holds TABLE_COUNT tables of 512 64-bit entries in one RAM; table t has
// physical frame pool_frame_base + t, table zero is the root. A map allocates
// missing intermediate tables from a bump counter and writes the leaf with the
// mapped frame and map_flags ORed in; a lookup stops at the first absent level.
// After reset the block runs a clearing pass that zeroes all TABLE_COUNT*512
// entries of the store; in_stall_o stays high meanwhile, config writes are
// taken at any time. Each level passes through a RAM read state and an
// evaluate state through the shared entry unit; a done state hands the result
// to the output register, then the block returns to idle to take the next
// item, and a walk that stops early skips the remaining levels. The single
// RAM port and the dependent chain of table reads limit the item rate. The
// output register lets the next item be accepted while a result still waits
// downstream. Config: pool_frame_base at byte address 0 (64-bit data, low 40
// bits used).

module page_table_walk_and_map_unit import ptwm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [VA_W-1:0]    virt_addr_i,
  input  wire logic [PA_W-1:0]    phys_addr_i,
  input  wire logic [ENTRY_W-1:0] map_flags_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [ENTRY_W-1:0] entry_value_o,
  output logic      [1:0]         status_o,
  output logic      [1:0]         fail_level_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  state_e state_q, state_d;

  // control state
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [NFREE_W-1:0] next_free_q, next_free_d;
  logic [FRAME_W-1:0] base_q;
  logic [1:0]         lvl_q, lvl_d;
  logic [TBL_W-1:0]   tbl_q, tbl_d;
  logic               out_valid_q, out_valid_d;

  // request payload
  logic               mode_q;
  logic [35:0]        vpn_q;
  logic [FRAME_W-1:0] pframe_q;
  logic [ENTRY_W-1:0] flags_q;

  // pending result and output register
  logic [ENTRY_W-1:0] res_value_q, res_value_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [1:0]         res_level_q, res_level_d;
  logic [ENTRY_W-1:0] out_value_q;
  logic [1:0]         out_status_q;
  logic [1:0]         out_level_q;

  logic               in_acc;
  logic               out_load;
  logic               cfg_wr;
  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               is_leaf;
  link_t              link;
  logic [ENTRY_W-1:0] merged;

  // ---------------------------------------------------------------------------
  // Config port: writes any time, single register at index 0
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_POOL_BASE) ? {24'h000000, base_q} : 64'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr && paddr[3] == REG_POOL_BASE) begin
      base_q <= pwdata[FRAME_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // Result moves into the output register once the slot is free this cycle
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = (out_valid_q && out_stall_i) || out_load;

  // ---------------------------------------------------------------------------
  // Walk address: current table plus this level's 9-bit index
  // ---------------------------------------------------------------------------
  always_comb begin
    case (lvl_q)
      2'd0:    idx = vpn_q[35:27];
      2'd1:    idx = vpn_q[26:18];
      2'd2:    idx = vpn_q[17:9];
      default: idx = vpn_q[8:0];
    endcase
  end

  assign walk_addr = {tbl_q, idx};
  assign is_leaf   = (lvl_q == LEVEL_LEAF);

  ptwm_entry_unit u_entry (
    .entry_i      (ram_rdata),
    .base_i       (base_q),
    .next_free_i  (next_free_q),
    .is_leaf_i    (is_leaf),
    .leaf_frame_i (pframe_q),
    .leaf_flags_i (flags_q),
    .link_o       (link),
    .merged_o     (merged)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    next_free_d  = next_free_q;
    lvl_d        = lvl_q;
    tbl_d        = tbl_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_level_d  = res_level_q;
    ram_we       = 1'b0;
    ram_waddr    = walk_addr;
    ram_wdata    = merged;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          lvl_d   = LEVEL_ROOT;
          tbl_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (is_leaf) begin
          // leaf is never tested for presence
          ram_we       = (mode_q == MODE_MAP);
          res_value_d  = (mode_q == MODE_MAP) ? merged : ram_rdata;
          res_status_d = ST_OK;
          res_level_d  = LEVEL_LEAF;
          state_d      = S_DONE;
        end else if (link.present) begin
          tbl_d   = link.tbl;
          lvl_d   = lvl_q + 1'b1;
          state_d = S_READ;
        end else if (mode_q == MODE_LOOKUP) begin
          res_value_d  = '0;
          res_status_d = ST_NOT_PRESENT;
          res_level_d  = lvl_q;
          state_d      = S_DONE;
        end else if (next_free_q == NFREE_W'(TABLE_COUNT)) begin
          res_value_d  = '0;
          res_status_d = ST_POOL_EMPTY;
          res_level_d  = lvl_q;
          state_d      = S_DONE;
        end else begin
          // link a fresh table; it is still all zero from the clearing pass
          ram_we      = 1'b1;
          tbl_d       = next_free_q[TBL_W-1:0];
          next_free_d = next_free_q + 1'b1;
          lvl_d       = lvl_q + 1'b1;
          state_d     = S_READ;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      next_free_q <= NFREE_W'(1);
      lvl_q       <= LEVEL_ROOT;
      tbl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_free_q <= next_free_d;
      lvl_q       <= lvl_d;
      tbl_q       <= tbl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= mode_i;
      vpn_q    <= virt_addr_i[VA_W-1:PAGE_SHIFT];
      pframe_q <= phys_addr_i[PA_W-1:PAGE_SHIFT];
      flags_q  <= map_flags_i;
    end
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_level_q  <= res_level_d;
    if (out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_level_q  <= res_level_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_value_q;
  assign status_o      = out_status_q;
  assign fail_level_o  = out_level_q;

  // ---------------------------------------------------------------------------
  // Table store
  // ---------------------------------------------------------------------------
  ptwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_READ),
    .raddr_i (walk_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_next_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q != '0 && next_free_q <= NFREE_W'(TABLE_COUNT))
    else $error("bump allocator out of range");

  a_next_free_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (next_free_q == $past(next_free_q)) ||
             (next_free_q == $past(next_free_q) + 1'b1))
    else $error("bump allocator moved by more than one");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> entry_value_o == '0)
    else $error("failed walk returned a nonzero entry");

  a_ok_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> fail_level_o == LEVEL_LEAF)
    else $error("successful walk did not end at the leaf");

endmodule

`default_nettype wire
